// ===== design/tgc_pkg.sv =====
// Package: shared types, register map and event codes for the touch gesture classifier.
package tgc_pkg;

  // Event codes as carried on the result channel
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_UP     = 3'd1;
  localparam logic [2:0] EV_DOWN   = 3'd2;
  localparam logic [2:0] EV_LEFT   = 3'd3;
  localparam logic [2:0] EV_RIGHT  = 3'd4;
  localparam logic [2:0] EV_TAP    = 3'd5;
  localparam logic [2:0] EV_DOUBLE = 3'd6;
  localparam logic [2:0] EV_LONG   = 3'd7;

  // Controller gesture codes
  localparam logic [7:0] GC_UP     = 8'h01;
  localparam logic [7:0] GC_DOWN   = 8'h02;
  localparam logic [7:0] GC_LEFT   = 8'h03;
  localparam logic [7:0] GC_RIGHT  = 8'h04;
  localparam logic [7:0] GC_TAP    = 8'h05;
  localparam logic [7:0] GC_DOUBLE = 8'h0B;
  localparam logic [7:0] GC_LONG   = 8'h0C;

  // Register indexes (byte address = 4 * index)
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_ROTATION      = 3'd0;
  localparam logic [2:0] REG_SWIPE_MIN     = 3'd1;
  localparam logic [2:0] REG_TAP_MAX_MOVE  = 3'd2;
  localparam logic [2:0] REG_SWIPE_MAX_MS  = 3'd3;
  localparam logic [2:0] REG_TAP_MAX_MS    = 3'd4;
  localparam logic [2:0] REG_DTAP_WINDOW   = 3'd5;
  localparam logic [2:0] REG_HOLDOFF_MS    = 3'd6;
  localparam logic [2:0] REG_GEST_REPEAT   = 3'd7;

  // Register reset values
  localparam logic [1:0]  RST_ROTATION     = 2'd0;
  localparam logic [11:0] RST_SWIPE_MIN    = 12'd50;
  localparam logic [11:0] RST_TAP_MAX_MOVE = 12'd35;
  localparam logic [15:0] RST_SWIPE_MAX_MS = 16'd800;
  localparam logic [15:0] RST_TAP_MAX_MS   = 16'd650;
  localparam logic [15:0] RST_DTAP_WINDOW  = 16'd350;
  localparam logic [15:0] RST_HOLDOFF_MS   = 16'd90;
  localparam logic [15:0] RST_GEST_REPEAT  = 16'd180;

  typedef struct packed {
    logic [1:0]  rotation;
    logic [11:0] swipe_min_distance;
    logic [11:0] tap_max_move;
    logic [15:0] swipe_max_ms;
    logic [15:0] tap_max_ms;
    logic [15:0] double_tap_window_ms;
    logic [15:0] repeat_holdoff_ms;
    logic [15:0] gesture_repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  raw_gesture;
    logic [3:0]  finger_count;
    logic [11:0] x_position;
    logic [11:0] y_position;
    logic [31:0] now_ms;
  } report_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [1:0] events_accepted;
    logic       pressed;
  } result_t;

endpackage

// ===== design/tgc_if.sv =====
// Interfaces: touch report channel and gesture result channel.
interface tgc_report_if;
  logic        valid;
  logic        ready;
  logic [7:0]  raw_gesture;
  logic [3:0]  finger_count;
  logic [11:0] x_position;
  logic [11:0] y_position;
  logic [31:0] now_ms;

  modport source (output valid, raw_gesture, finger_count, x_position, y_position, now_ms,
                  input ready);
  modport sink (input valid, raw_gesture, finger_count, x_position, y_position, now_ms,
                output ready);
endinterface

interface tgc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic [1:0] events_accepted;
  logic       pressed;

  modport source (output valid, event_code, events_accepted, pressed, input ready);
  modport sink (input valid, event_code, events_accepted, pressed, output ready);
endinterface

// ===== design/touch_gesture_classifier_core.sv =====
// Touch gesture classifier: an input register, one pass of compare logic through the
// engine, and a result register; one report is accepted per cycle unless the result
// side stalls, and its result passes through the report and result registers to the
// result channel. The single-pass compare and subtract logic between the two registers
// sets this rate, and a stalled result register still lets one more report be taken into
// the report register. Configuration registers sit at byte address 4*index on the
// APB-style port; the user must write them only while idle, unchecked by the block.
module touch_gesture_classifier_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tgc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  tgc_report_if.sink                 report,
  tgc_result_if.source               result
);

  tgc_pkg::cfg_t    cfg;
  tgc_pkg::report_t rpt_in, rpt_q;
  tgc_pkg::result_t res_d, res_q;
  logic             rpt_valid, res_valid, step, take_report;

  assign pready = 1'b1;

  // Configuration registers
  tgc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Handshake: the engine steps when the result register is free or being drained
  assign step         = rpt_valid && (!res_valid || result.ready);
  assign report.ready = !rpt_valid || step;
  assign take_report  = report.valid && report.ready;

  assign rpt_in.raw_gesture  = report.raw_gesture;
  assign rpt_in.finger_count = report.finger_count;
  assign rpt_in.x_position   = report.x_position;
  assign rpt_in.y_position   = report.y_position;
  assign rpt_in.now_ms       = report.now_ms;

  // Report register
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (take_report) begin
      rpt_valid <= 1'b1;
    end else if (step) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_report) begin
      rpt_q <= rpt_in;
    end
  end

  tgc_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .rpt  (rpt_q),
    .cfg  (cfg),
    .res  (res_d)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign result.valid           = res_valid;
  assign result.event_code      = res_q.event_code;
  assign result.events_accepted = res_q.events_accepted;
  assign result.pressed         = res_q.pressed;

`ifndef SYNTHESIS
  // At most two events per report
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_q.events_accepted != 2'd3))
    else $error("events_accepted out of range");

  // An event code is shown exactly when something was accepted
  a_code_matches_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_q.event_code == tgc_pkg::EV_NONE) == (res_q.events_accepted == 2'd0)))
    else $error("event_code and events_accepted disagree");

  // Back-pressure only when both registers are full
  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    !report.ready |-> (rpt_valid && res_valid && !result.ready))
    else $error("report channel stalled with room available");

  // A held report is never dropped while the result side is stalled
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && res_valid && !result.ready) |=> rpt_valid)
    else $error("report lost during stall");
`endif

endmodule

// ===== design/tgc_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
module tgc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tgc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output tgc_pkg::cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[tgc_pkg::ADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation             <= tgc_pkg::RST_ROTATION;
      cfg.swipe_min_distance   <= tgc_pkg::RST_SWIPE_MIN;
      cfg.tap_max_move         <= tgc_pkg::RST_TAP_MAX_MOVE;
      cfg.swipe_max_ms         <= tgc_pkg::RST_SWIPE_MAX_MS;
      cfg.tap_max_ms           <= tgc_pkg::RST_TAP_MAX_MS;
      cfg.double_tap_window_ms <= tgc_pkg::RST_DTAP_WINDOW;
      cfg.repeat_holdoff_ms    <= tgc_pkg::RST_HOLDOFF_MS;
      cfg.gesture_repeat_ms    <= tgc_pkg::RST_GEST_REPEAT;
    end else if (wr_en) begin
      case (reg_idx)
        tgc_pkg::REG_ROTATION:     cfg.rotation             <= pwdata[1:0];
        tgc_pkg::REG_SWIPE_MIN:    cfg.swipe_min_distance   <= pwdata[11:0];
        tgc_pkg::REG_TAP_MAX_MOVE: cfg.tap_max_move         <= pwdata[11:0];
        tgc_pkg::REG_SWIPE_MAX_MS: cfg.swipe_max_ms         <= pwdata[15:0];
        tgc_pkg::REG_TAP_MAX_MS:   cfg.tap_max_ms           <= pwdata[15:0];
        tgc_pkg::REG_DTAP_WINDOW:  cfg.double_tap_window_ms <= pwdata[15:0];
        tgc_pkg::REG_HOLDOFF_MS:   cfg.repeat_holdoff_ms    <= pwdata[15:0];
        tgc_pkg::REG_GEST_REPEAT:  cfg.gesture_repeat_ms    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      tgc_pkg::REG_ROTATION:     prdata = {30'd0, cfg.rotation};
      tgc_pkg::REG_SWIPE_MIN:    prdata = {20'd0, cfg.swipe_min_distance};
      tgc_pkg::REG_TAP_MAX_MOVE: prdata = {20'd0, cfg.tap_max_move};
      tgc_pkg::REG_SWIPE_MAX_MS: prdata = {16'd0, cfg.swipe_max_ms};
      tgc_pkg::REG_TAP_MAX_MS:   prdata = {16'd0, cfg.tap_max_ms};
      tgc_pkg::REG_DTAP_WINDOW:  prdata = {16'd0, cfg.double_tap_window_ms};
      tgc_pkg::REG_HOLDOFF_MS:   prdata = {16'd0, cfg.repeat_holdoff_ms};
      tgc_pkg::REG_GEST_REPEAT:  prdata = {16'd0, cfg.gesture_repeat_ms};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/tgc_engine.sv =====
// Gesture engine: press tracking state, code mapping, release classification and hold-off.
module tgc_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tgc_pkg::report_t rpt,
  input  tgc_pkg::cfg_t    cfg,
  output tgc_pkg::result_t res
);

  // Tracking state
  logic        press_active, press_active_next;
  logic [11:0] start_x, start_x_next, start_y, start_y_next;
  logic [11:0] latest_x, latest_x_next, latest_y, latest_y_next;
  logic [31:0] press_start_time, press_start_time_next;
  logic [31:0] prior_tap_time, prior_tap_time_next;
  logic [2:0]  prior_event, prior_event_next;
  logic [31:0] prior_event_time, prior_event_time_next;
  logic [7:0]  prior_gesture_code, prior_gesture_code_next;

  logic [2:0]  ev1, ev2, pe1;
  logic [31:0] since_event, since_event2, duration, since_tap;
  logic        gesture_pass, acc1, acc2, release_now;
  logic signed [12:0] dx, dy, rdx, rdy;
  logic [11:0] adx, ady;
  logic        is_swipe, tap_ok, short_press, is_double;

  // Controller code to event, swipes rotated by orientation
  always_comb begin
    case (rpt.raw_gesture)
      tgc_pkg::GC_UP, tgc_pkg::GC_DOWN, tgc_pkg::GC_LEFT, tgc_pkg::GC_RIGHT: begin
        case ({cfg.rotation, rpt.raw_gesture[1:0]})
          4'b00_01: ev1 = tgc_pkg::EV_UP;
          4'b00_10: ev1 = tgc_pkg::EV_DOWN;
          4'b00_11: ev1 = tgc_pkg::EV_LEFT;
          4'b00_00: ev1 = tgc_pkg::EV_RIGHT;
          4'b01_01: ev1 = tgc_pkg::EV_LEFT;
          4'b01_10: ev1 = tgc_pkg::EV_RIGHT;
          4'b01_11: ev1 = tgc_pkg::EV_DOWN;
          4'b01_00: ev1 = tgc_pkg::EV_UP;
          4'b10_01: ev1 = tgc_pkg::EV_DOWN;
          4'b10_10: ev1 = tgc_pkg::EV_UP;
          4'b10_11: ev1 = tgc_pkg::EV_RIGHT;
          4'b10_00: ev1 = tgc_pkg::EV_LEFT;
          4'b11_01: ev1 = tgc_pkg::EV_RIGHT;
          4'b11_10: ev1 = tgc_pkg::EV_LEFT;
          4'b11_11: ev1 = tgc_pkg::EV_UP;
          default:  ev1 = tgc_pkg::EV_DOWN;
        endcase
      end
      tgc_pkg::GC_TAP:    ev1 = tgc_pkg::EV_TAP;
      tgc_pkg::GC_DOUBLE: ev1 = tgc_pkg::EV_DOUBLE;
      tgc_pkg::GC_LONG:   ev1 = tgc_pkg::EV_LONG;
      default:            ev1 = tgc_pkg::EV_NONE;
    endcase
  end

  // Repeat filter and hold-off for the controller event
  assign since_event  = rpt.now_ms - prior_event_time;
  assign gesture_pass = (ev1 != tgc_pkg::EV_NONE) &&
                        ((rpt.raw_gesture != prior_gesture_code) ||
                         (since_event >= {16'd0, cfg.gesture_repeat_ms}));
  assign acc1 = gesture_pass &&
                !((ev1 == prior_event) && (since_event < {16'd0, cfg.repeat_holdoff_ms}));
  assign pe1          = acc1 ? ev1 : prior_event;
  assign since_event2 = acc1 ? 32'd0 : since_event;

  // Movement from start to last point, rotated
  assign release_now = (rpt.finger_count == 4'd0) && press_active;
  assign duration    = rpt.now_ms - press_start_time;
  assign dx = $signed({1'b0, latest_x}) - $signed({1'b0, start_x});
  assign dy = $signed({1'b0, latest_y}) - $signed({1'b0, start_y});

  always_comb begin
    case (cfg.rotation)
      2'd1: begin rdx = -dy; rdy = dx;  end
      2'd2: begin rdx = -dx; rdy = -dy; end
      2'd3: begin rdx = dy;  rdy = -dx; end
      default: begin rdx = dx; rdy = dy; end
    endcase
  end

  assign adx = rdx[12] ? 12'(-rdx) : rdx[11:0];
  assign ady = rdy[12] ? 12'(-rdy) : rdy[11:0];

  // Release classification
  assign is_swipe    = (duration <= {16'd0, cfg.swipe_max_ms}) &&
                       ((adx > cfg.swipe_min_distance) || (ady > cfg.swipe_min_distance));
  assign tap_ok      = (adx <= cfg.tap_max_move) && (ady <= cfg.tap_max_move);
  assign short_press = duration <= {16'd0, cfg.tap_max_ms};
  assign since_tap   = rpt.now_ms - prior_tap_time;
  assign is_double   = since_tap <= {16'd0, cfg.double_tap_window_ms};

  always_comb begin
    if (!release_now) begin
      ev2 = tgc_pkg::EV_NONE;
    end else if (is_swipe) begin
      if (adx >= ady) ev2 = (!rdx[12] && rdx != 13'sd0) ? tgc_pkg::EV_RIGHT : tgc_pkg::EV_LEFT;
      else            ev2 = (!rdy[12] && rdy != 13'sd0) ? tgc_pkg::EV_DOWN : tgc_pkg::EV_UP;
    end else if (!tap_ok) begin
      ev2 = tgc_pkg::EV_NONE;
    end else if (short_press) begin
      ev2 = is_double ? tgc_pkg::EV_DOUBLE : tgc_pkg::EV_TAP;
    end else begin
      ev2 = tgc_pkg::EV_LONG;
    end
  end

  // Hold-off for the release event, seen after the controller event's update
  assign acc2 = (ev2 != tgc_pkg::EV_NONE) &&
                !((ev2 == pe1) && (since_event2 < {16'd0, cfg.repeat_holdoff_ms}));

  // Next state
  always_comb begin
    press_active_next       = rpt.finger_count != 4'd0;
    start_x_next            = start_x;
    start_y_next            = start_y;
    press_start_time_next   = press_start_time;
    latest_x_next           = latest_x;
    latest_y_next           = latest_y;
    prior_tap_time_next     = prior_tap_time;
    prior_event_next        = pe1;
    prior_event_time_next   = acc1 ? rpt.now_ms : prior_event_time;
    prior_gesture_code_next = gesture_pass ? rpt.raw_gesture : prior_gesture_code;
    if (rpt.finger_count != 4'd0) begin
      if (!press_active) begin
        start_x_next          = rpt.x_position;
        start_y_next          = rpt.y_position;
        press_start_time_next = rpt.now_ms;
      end
      latest_x_next = rpt.x_position;
      latest_y_next = rpt.y_position;
    end
    if (release_now && !is_swipe && tap_ok && short_press) begin
      prior_tap_time_next = is_double ? 32'd0 : rpt.now_ms;
    end
    if (acc2) begin
      prior_event_next      = ev2;
      prior_event_time_next = rpt.now_ms;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      press_active       <= 1'b0;
      start_x            <= 12'd0;
      start_y            <= 12'd0;
      latest_x           <= 12'd0;
      latest_y           <= 12'd0;
      press_start_time   <= 32'd0;
      prior_tap_time     <= 32'd0;
      prior_event        <= tgc_pkg::EV_NONE;
      prior_event_time   <= 32'd0;
      prior_gesture_code <= 8'd0;
    end else if (step) begin
      press_active       <= press_active_next;
      start_x            <= start_x_next;
      start_y            <= start_y_next;
      latest_x           <= latest_x_next;
      latest_y           <= latest_y_next;
      press_start_time   <= press_start_time_next;
      prior_tap_time     <= prior_tap_time_next;
      prior_event        <= prior_event_next;
      prior_event_time   <= prior_event_time_next;
      prior_gesture_code <= prior_gesture_code_next;
    end
  end

  // Result of this item
  assign res.event_code      = acc2 ? ev2 : (acc1 ? ev1 : tgc_pkg::EV_NONE);
  assign res.events_accepted = {1'b0, acc1} + {1'b0, acc2};
  assign res.pressed         = press_active_next;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the touch gesture classifier: directed and random report traffic, self-checked.
`timescale 1ns / 1ps

module tb_top;
  import tgc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam logic [7:0] GC_NONE = 8'h00;

  typedef enum int {SET_RESET, SET_ZERO, SET_FULL, SET_RANDOM} setting_style_t;

  // Press tracking and filter history held by the predictor
  typedef struct packed {
    logic        active;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [11:0] last_x;
    logic [11:0] last_y;
    logic [31:0] press_t;
    logic [31:0] tap_t;
    logic [31:0] event_t;
    logic [2:0]  last_event;
    logic [7:0]  last_code;
  } press_track_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tgc_report_if report_ch ();
  tgc_result_if result_ch ();

  touch_gesture_classifier_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .report  (report_ch),
    .result  (result_ch)
  );

  cfg_t         regs_model;
  press_track_t trk;
  result_t      item_res;
  result_t      pending_results[$];

  int unsigned  snd_idle_pct;
  int unsigned  rcv_idle_pct;
  int unsigned  mismatches;
  int unsigned  reports_sent;
  int unsigned  results_checked;
  int unsigned  settings_applied;
  int unsigned  quiet_cycles;
  logic [31:0]  now_cur;
  logic [7:0]   last_code;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Controller code to event; swipes turn with the screen orientation
  function automatic logic [2:0] map_code(input logic [7:0] code);
    logic [1:0] pos;
    case (code)
      GC_UP:     pos = 2'd0;
      GC_LEFT:   pos = 2'd1;
      GC_DOWN:   pos = 2'd2;
      GC_RIGHT:  pos = 2'd3;
      GC_TAP:    return EV_TAP;
      GC_DOUBLE: return EV_DOUBLE;
      GC_LONG:   return EV_LONG;
      default:   return EV_NONE;
    endcase
    // compass order up, left, down, right; each quarter turn steps once
    pos = pos + regs_model.rotation;
    case (pos)
      2'd0:    return EV_UP;
      2'd1:    return EV_LEFT;
      2'd2:    return EV_DOWN;
      default: return EV_RIGHT;
    endcase
  endfunction

  // Hold-off: drop an identical event inside the window
  function automatic void offer_event(input logic [2:0] ev, input logic [31:0] now);
    if (ev == trk.last_event && (now - trk.event_t) < regs_model.repeat_holdoff_ms) return;
    trk.last_event = ev;
    trk.event_t = now;
    item_res.event_code = ev;
    item_res.events_accepted = item_res.events_accepted + 2'd1;
  endfunction

  // Press tracking and classification on release
  function automatic void track_point(input report_t r);
    int dx, dy, rdx, rdy, adx, ady;
    logic [31:0] dur;
    if (r.finger_count != 4'd0) begin
      if (!trk.active) begin
        trk.active = 1'b1;
        trk.start_x = r.x_position;
        trk.start_y = r.y_position;
        trk.press_t = r.now_ms;
      end
      trk.last_x = r.x_position;
      trk.last_y = r.y_position;
      return;
    end
    if (!trk.active) return;
    trk.active = 1'b0;
    dur = r.now_ms - trk.press_t;
    dx = int'(trk.last_x) - int'(trk.start_x);
    dy = int'(trk.last_y) - int'(trk.start_y);
    case (regs_model.rotation)
      2'd1:    begin rdx = -dy; rdy = dx;  end
      2'd2:    begin rdx = -dx; rdy = -dy; end
      2'd3:    begin rdx = dy;  rdy = -dx; end
      default: begin rdx = dx;  rdy = dy;  end
    endcase
    adx = (rdx < 0) ? -rdx : rdx;
    ady = (rdy < 0) ? -rdy : rdy;
    // short press with enough travel: swipe along the larger axis, ties horizontal
    if (dur <= regs_model.swipe_max_ms && (adx > int'(regs_model.swipe_min_distance) ||
        ady > int'(regs_model.swipe_min_distance))) begin
      if (adx >= ady) offer_event((rdx > 0) ? EV_RIGHT : EV_LEFT, r.now_ms);
      else offer_event((rdy > 0) ? EV_DOWN : EV_UP, r.now_ms);
      return;
    end
    if (adx > int'(regs_model.tap_max_move) || ady > int'(regs_model.tap_max_move)) return;
    if (dur <= regs_model.tap_max_ms) begin
      // second tap inside the window pairs up and clears the tap time
      if ((r.now_ms - trk.tap_t) <= regs_model.double_tap_window_ms) begin
        trk.tap_t = '0;
        offer_event(EV_DOUBLE, r.now_ms);
      end else begin
        trk.tap_t = r.now_ms;
        offer_event(EV_TAP, r.now_ms);
      end
    end else begin
      offer_event(EV_LONG, r.now_ms);
    end
  endfunction

  function automatic result_t classify_report(input report_t r);
    logic [2:0] ev;
    item_res = '0;
    ev = map_code(r.raw_gesture);
    // repeated controller code within the window is ignored
    if (ev != EV_NONE && (r.raw_gesture != trk.last_code ||
        (r.now_ms - trk.event_t) >= regs_model.gesture_repeat_ms)) begin
      offer_event(ev, r.now_ms);
      trk.last_code = r.raw_gesture;
    end
    track_point(r);
    item_res.pressed = trk.active;
    return item_res;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers and result checker
  // ---------------------------------------------------------------------------

  // Result channel back-pressure
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Send one report beat; called at a falling edge, returns at a falling edge
  task automatic send_report(input logic [7:0] code, input logic [3:0] fingers,
                             input logic [11:0] x, input logic [11:0] y,
                             input logic [31:0] stamp);
    report_t r;
    r.raw_gesture = code;
    r.finger_count = fingers;
    r.x_position = x;
    r.y_position = y;
    r.now_ms = stamp;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      report_ch.valid <= 1'b0;
      @(negedge clk);
    end
    report_ch.valid <= 1'b1;
    report_ch.raw_gesture <= code;
    report_ch.finger_count <= fingers;
    report_ch.x_position <= x;
    report_ch.y_position <= y;
    report_ch.now_ms <= stamp;
    @(posedge clk);
    while (!report_ch.ready) @(posedge clk);
    pending_results.push_back(classify_report(r));
    reports_sent++;
    @(negedge clk);
  endtask

  // Compare each result beat with the oldest pending expectation
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready) begin
      got.event_code = result_ch.event_code;
      got.events_accepted = result_ch.events_accepted;
      got.pressed = result_ch.pressed;
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result beat: ev=%0d cnt=%0d pressed=%0d",
                             got.event_code, got.events_accepted, got.pressed));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.event_code !== want.event_code ||
            got.events_accepted !== want.events_accepted ||
            got.pressed !== want.pressed) begin
          note_error($sformatf(
            "result %0d: expected ev=%0d cnt=%0d pressed=%0d, got ev=%0d cnt=%0d pressed=%0d",
            results_checked, want.event_code, want.events_accepted, want.pressed,
            got.event_code, got.events_accepted, got.pressed));
        end
      end
    end
  end

  // Watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if (rst || (report_ch.valid && report_ch.ready) ||
        (result_ch.valid === 1'b1 && result_ch.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Drain: stop sending, wait for every result, then cover the pipeline depth
  task automatic settle();
    report_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write then read-back of one register
  task automatic program_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] rd;
    case (idx)
      REG_ROTATION:     begin mask = 32'h3;    regs_model.rotation = value[1:0]; end
      REG_SWIPE_MIN:    begin mask = 32'hFFF;  regs_model.swipe_min_distance = value[11:0]; end
      REG_TAP_MAX_MOVE: begin mask = 32'hFFF;  regs_model.tap_max_move = value[11:0]; end
      REG_SWIPE_MAX_MS: begin mask = 32'hFFFF; regs_model.swipe_max_ms = value[15:0]; end
      REG_TAP_MAX_MS:   begin mask = 32'hFFFF; regs_model.tap_max_ms = value[15:0]; end
      REG_DTAP_WINDOW:  begin mask = 32'hFFFF; regs_model.double_tap_window_ms = value[15:0]; end
      REG_HOLDOFF_MS:   begin mask = 32'hFFFF; regs_model.repeat_holdoff_ms = value[15:0]; end
      default:          begin mask = 32'hFFFF; regs_model.gesture_repeat_ms = value[15:0]; end
    endcase
    // setup then access; bits above the field are junk
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= (value & mask) | ($urandom & ~mask);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== (value & mask))
      note_error($sformatf("register %0d read-back: expected %0h, got %0h",
                           idx, value & mask, rd));
  endtask

  task automatic apply_settings(input setting_style_t style, input logic [1:0] rot);
    cfg_t nc;
    settle();
    case (style)
      SET_RESET: begin
        nc.swipe_min_distance = RST_SWIPE_MIN;
        nc.tap_max_move = RST_TAP_MAX_MOVE;
        nc.swipe_max_ms = RST_SWIPE_MAX_MS;
        nc.tap_max_ms = RST_TAP_MAX_MS;
        nc.double_tap_window_ms = RST_DTAP_WINDOW;
        nc.repeat_holdoff_ms = RST_HOLDOFF_MS;
        nc.gesture_repeat_ms = RST_GEST_REPEAT;
      end
      SET_ZERO: nc = '0;
      SET_FULL: nc = '1;
      default: begin
        nc.swipe_min_distance = 12'($urandom_range(0, 400));
        nc.tap_max_move = 12'($urandom_range(0, 150));
        nc.swipe_max_ms = 16'($urandom_range(0, 1500));
        nc.tap_max_ms = 16'($urandom_range(0, 1500));
        nc.double_tap_window_ms = 16'($urandom_range(0, 1000));
        nc.repeat_holdoff_ms = 16'($urandom_range(0, 600));
        nc.gesture_repeat_ms = 16'($urandom_range(0, 600));
      end
    endcase
    nc.rotation = rot;
    program_reg(REG_ROTATION, 32'(nc.rotation));
    program_reg(REG_SWIPE_MIN, 32'(nc.swipe_min_distance));
    program_reg(REG_TAP_MAX_MOVE, 32'(nc.tap_max_move));
    program_reg(REG_SWIPE_MAX_MS, 32'(nc.swipe_max_ms));
    program_reg(REG_TAP_MAX_MS, 32'(nc.tap_max_ms));
    program_reg(REG_DTAP_WINDOW, 32'(nc.double_tap_window_ms));
    program_reg(REG_HOLDOFF_MS, 32'(nc.repeat_holdoff_ms));
    program_reg(REG_GEST_REPEAT, 32'(nc.gesture_repeat_ms));
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Mostly no controller code, some mapped codes with repeats, some junk
  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return GC_NONE;
      6, 7: begin
        case ($urandom_range(0, 6))
          0:       last_code = GC_UP;
          1:       last_code = GC_DOWN;
          2:       last_code = GC_LEFT;
          3:       last_code = GC_RIGHT;
          4:       last_code = GC_TAP;
          5:       last_code = GC_DOUBLE;
          default: last_code = GC_LONG;
        endcase
        return last_code;
      end
      8:       return last_code;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Move a coordinate by d in a random direction, kept on the panel
  function automatic logic [11:0] offset_coord(input logic [11:0] c, input int d);
    int v;
    v = $urandom_range(0, 1) ? int'(c) + d : int'(c) - d;
    if (v < 0) v = int'(c) + d;
    if (v > 4095) v = int'(c) - d;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // One press/move/release sequence shaped around the current thresholds, or noise
  task automatic send_gesture_sequence();
    int kind, moves, dur, span, ddx, ddy;
    logic [11:0] sx, sy, ex, ey;
    logic [31:0] t0, t;
    kind = $urandom_range(0, 9);
    case ($urandom_range(0, 3))
      0:       now_cur += $urandom_range(0, regs_model.repeat_holdoff_ms + 20);
      1:       now_cur += $urandom_range(0, regs_model.double_tap_window_ms + 50);
      2:       now_cur += $urandom_range(0, 3000);
      default: now_cur += $urandom;
    endcase
    if (kind >= 8) begin
      repeat ($urandom_range(1, 4)) begin
        now_cur += $urandom_range(0, 1) ? $urandom_range(0, 500) : $urandom;
        send_report(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                    12'($urandom), 12'($urandom), now_cur);
      end
    end else begin
      sx = 12'($urandom);
      sy = 12'($urandom);
      ddx = 0;
      ddy = 0;
      case (kind)
        4, 5: begin
          span = ($urandom_range(0, 7) == 0) ? int'(regs_model.swipe_min_distance) :
                 int'(regs_model.swipe_min_distance) + 1 + $urandom_range(0, 300);
          case ($urandom_range(0, 3))
            0:       ddx = span;
            1:       ddy = span;
            2:       begin ddx = span; ddy = span; end
            default: begin ddx = span; ddy = $urandom_range(0, span + 50); end
          endcase
          dur = ($urandom_range(0, 7) == 0) ? regs_model.swipe_max_ms + $urandom_range(0, 1) :
                $urandom_range(0, regs_model.swipe_max_ms);
        end
        6: begin
          ddx = $urandom_range(0, regs_model.tap_max_move);
          ddy = $urandom_range(0, regs_model.tap_max_move);
          dur = regs_model.tap_max_ms + 1 + $urandom_range(0, 400);
        end
        7: begin
          ddx = $urandom_range(0, 4095);
          ddy = $urandom_range(0, 4095);
          dur = $urandom_range(0, 2000);
        end
        default: begin
          ddx = $urandom_range(0, regs_model.tap_max_move);
          ddy = $urandom_range(0, regs_model.tap_max_move);
          if ($urandom_range(0, 7) == 0) ddx = regs_model.tap_max_move + 1;
          dur = ($urandom_range(0, 7) == 0) ? regs_model.tap_max_ms + $urandom_range(0, 1) :
                $urandom_range(0, regs_model.tap_max_ms);
        end
      endcase
      moves = (kind == 4 || kind == 5) ? $urandom_range(1, 3) : $urandom_range(0, 3);
      ex = offset_coord(sx, ddx);
      ey = offset_coord(sy, ddy);
      t0 = now_cur;
      t = t0;
      send_report(pick_code(), 4'($urandom_range(1, 15)), sx, sy, t);
      for (int i = 1; i <= moves; i++) begin
        t += $urandom_range(0, dur / 4);
        if (i == moves)
          send_report(pick_code(), 4'($urandom_range(1, 15)), ex, ey, t);
        else
          send_report(pick_code(), 4'($urandom_range(1, 15)), 12'($urandom), 12'($urandom), t);
      end
      now_cur = t0 + dur;
      send_report(pick_code(), 4'd0, 12'($urandom), 12'($urandom), now_cur);
    end
  endtask

  task automatic run_traffic(input int unsigned n);
    int unsigned target;
    target = reports_sent + n;
    while (reports_sent < target) send_gesture_sequence();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset thresholds: every controller code, filters, each release class, wrap
  task automatic test_directed();
    send_report(GC_NONE, 4'd0, 12'hFFF, 12'hFFF, 32'd0);        // release with no press
    send_report(GC_TAP, 4'd15, 12'd2000, 12'd2000, 32'd100);    // code and press together
    send_report(GC_NONE, 4'd0, 12'd0, 12'd0, 32'd150);          // tap soon after time zero
    send_report(GC_TAP, 4'd0, 12'd0, 12'd0, 32'd200);           // repeated code, ignored
    send_report(GC_DOUBLE, 4'd0, 12'd0, 12'd0, 32'd210);        // same event inside hold-off
    send_report(8'hFF, 4'd0, 12'd0, 12'd0, 32'd400);            // unmapped code
    send_report(GC_UP, 4'd0, 12'd0, 12'd0, 32'd1000);
    send_report(GC_DOWN, 4'd0, 12'd0, 12'd0, 32'd1200);
    send_report(GC_LEFT, 4'd0, 12'd0, 12'd0, 32'd1400);
    send_report(GC_RIGHT, 4'd0, 12'd0, 12'd0, 32'd1600);
    send_report(GC_LONG, 4'd0, 12'd0, 12'd0, 32'd1800);
    // diagonal swipe with equal travel plus a tap code: two events in one beat
    send_report(GC_NONE, 4'd1, 12'd100, 12'd100, 32'd5000);
    send_report(GC_NONE, 4'd2, 12'd200, 12'd200, 32'd5100);
    send_report(GC_TAP, 4'd0, 12'd0, 12'd0, 32'd5200);
    // tap, then a second tap inside the window
    send_report(GC_NONE, 4'd1, 12'd0, 12'd0, 32'd10000);
    send_report(GC_NONE, 4'd0, 12'd0, 12'd0, 32'd10100);
    send_report(GC_NONE, 4'd8, 12'd0, 12'hFFF, 32'd10200);
    send_report(GC_NONE, 4'd0, 12'd0, 12'd0, 32'd10300);
    // long press with small drift
    send_report(GC_NONE, 4'd3, 12'hFFF, 12'd0, 32'd20000);
    send_report(GC_NONE, 4'd3, 12'd4070, 12'd30, 32'd20500);
    send_report(GC_NONE, 4'd0, 12'd0, 12'd0, 32'd21000);
    // vertical swipe up
    send_report(GC_NONE, 4'd1, 12'd1000, 12'd3000, 32'd30000);
    send_report(GC_NONE, 4'd1, 12'd1010, 12'd100, 32'd30100);
    send_report(GC_NONE, 4'd0, 12'd0, 12'd0, 32'd30200);
    // press spanning the timestamp wrap
    send_report(GC_NONE, 4'd5, 12'd500, 12'd500, 32'hFFFF_FF00);
    send_report(GC_NONE, 4'd0, 12'd0, 12'd0, 32'h0000_0010);
    now_cur = 32'h0000_0010;
  endtask

  // Reset thresholds under each screen orientation
  task automatic test_orientation();
    for (int rot = 0; rot < 4; rot++) begin
      apply_settings(SET_RESET, 2'(rot));
      run_traffic(100);
    end
  endtask

  // All thresholds at zero, then at full scale
  task automatic test_threshold_extremes();
    apply_settings(SET_ZERO, 2'($urandom_range(0, 3)));
    run_traffic(150);
    apply_settings(SET_FULL, 2'($urandom_range(0, 3)));
    run_traffic(150);
  endtask

  task automatic test_random_settings(input int phases, input int unsigned per_phase);
    repeat (phases) begin
      apply_settings(SET_RANDOM, 2'($urandom_range(0, 3)));
      run_traffic(per_phase);
    end
  endtask

  initial begin : main_seq
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    report_ch.valid = 1'b0;
    report_ch.raw_gesture = '0;
    report_ch.finger_count = '0;
    report_ch.x_position = '0;
    report_ch.y_position = '0;
    report_ch.now_ms = '0;
    snd_idle_pct = 13;
    rcv_idle_pct = 51;
    mismatches = 0;
    reports_sent = 0;
    results_checked = 0;
    settings_applied = 0;
    quiet_cycles = 0;
    now_cur = '0;
    last_code = GC_TAP;
    trk = '0;
    regs_model.rotation = RST_ROTATION;
    regs_model.swipe_min_distance = RST_SWIPE_MIN;
    regs_model.tap_max_move = RST_TAP_MAX_MOVE;
    regs_model.swipe_max_ms = RST_SWIPE_MAX_MS;
    regs_model.tap_max_ms = RST_TAP_MAX_MS;
    regs_model.double_tap_window_ms = RST_DTAP_WINDOW;
    regs_model.repeat_holdoff_ms = RST_HOLDOFF_MS;
    regs_model.gesture_repeat_ms = RST_GEST_REPEAT;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sender idles lightly, receiver stalls often
    test_directed();
    test_orientation();

    // receiver stalls lightly, sender idles often
    snd_idle_pct = 51;
    rcv_idle_pct = 13;
    test_threshold_extremes();
    test_random_settings(4, 125);

    // full rate both ways
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_settings(4, 100);

    settle();
    repeat (8) @(negedge clk);
    $display("Sent %0d touch reports, checked %0d results over %0d register settings;",
             reports_sent, results_checked, settings_applied);
    $display("all orientations, zero and full-scale thresholds, three stall patterns.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, pending_results.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tgc_pkg.sv
design/tgc_if.sv
design/tgc_cfg_regs.sv
design/tgc_engine.sv
design/touch_gesture_classifier_core.sv
tb/tb_top.sv
